@@ rtl/accel_tilt_quaternion_estimator_core_assert.svh @@
// Assertion macros for the tilt estimator checker.
// Depends on nothing; included by the checker file only.
`ifndef ACCEL_TILT_QUATERNION_ESTIMATOR_CORE_ASSERT_SVH
`define ACCEL_TILT_QUATERNION_ESTIMATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ATQE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atqe: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define ATQE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atqe: next-cycle property failed");

`endif

@@ rtl/atqe_pkg.sv @@
// Shared types, widths and constants of the tilt estimator.
// No dependencies; imported by every module of the block.
`default_nettype none
package atqe_pkg;

    localparam int ACCEL_W   = 24;
    localparam int COUNT_W   = 16;
    localparam int TIME_W    = 32;
    localparam int SUM_W     = 40;
    localparam int GRAV_W    = 24;
    localparam int QUAT_W    = 16;
    localparam int VAR_W     = 32;
    localparam int MIN_W     = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int AXIS_W    = 2;

    localparam int AMAG_W  = 25;
    localparam int OPND_W  = 28;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = 56;
    localparam int SQ_IN_W = 56;
    localparam int SQ_ITER = SQ_IN_W / 2;
    localparam int ROOT_W  = SQ_ITER + 1;
    localparam int DVD_W   = 80;
    localparam int DVS_W   = 48;
    localparam int QUO_W   = 32;
    localparam int ITER_W  = 7;

    localparam logic [ITER_W-1:0] DIV_N_CAL  = ITER_W'(41);
    localparam logic [ITER_W-1:0] DIV_N_QUAT = ITER_W'(41);
    localparam logic [ITER_W-1:0] DIV_N_VAR  = ITER_W'(75);

    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(2);

    localparam logic [TIME_W-1:0]        CALIB_DUR_RST  = 32'd1000000;
    localparam logic [CFG_W-1:0]         NOISE_RST      = 32'd0;
    localparam logic [MIN_W-1:0]         MIN_CAL_RST    = 16'd10;
    localparam logic [GRAV_W-1:0]        GRAVITY_RST    = 24'd642908;
    localparam logic [GRAV_W-1:0]        GRAV_SAT       = 24'hFF_FFFF;
    localparam logic signed [QUAT_W-1:0] Q14_ONE        = 16'sd16384;
    localparam logic [VAR_W-1:0]         ONE_Q24        = 32'd16777216;
    localparam logic [VAR_W-1:0]         HALF_PI_SQ_Q24 = 32'd41396121;
    localparam logic [VAR_W-1:0]         VAR_SAT        = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CALIB_DUR = 2'd0,
        REG_NOISE     = 2'd1,
        REG_MIN_CAL   = 2'd2
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_C_DIV, S_C_DIVW, S_C_MUL, S_C_ACC, S_C_SQ, S_C_SQW,
        S_R_MUL, S_R_ACC, S_R_SQ, S_R_SQW, S_R_CHK,
        S_N_MUL, S_N_ACC, S_N_CHK, S_N_SQW,
        S_Q_DIV, S_Q_DIVW,
        S_V_START, S_V_MULD, S_V_ACCD, S_V_NOISE, S_V_DIV, S_V_DIVW,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_AXIS, MUL_NORM, MUL_QUO, MUL_DIFF, MUL_GRAV
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_CLR, ACC_ADD, ACC_NOISE
    } acc_op_t;

    typedef enum logic [1:0] {
        DIV_CAL, DIV_QUAT, DIV_VAR
    } div_op_t;

    typedef struct packed {
        logic     in_load;
        logic     cal_step;
        logic     axis_clr;
        logic     axis_inc;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     sqrt_start;
        logic     div_start;
        div_op_t  div_op;
        logic     amag_load;
        logic     nroot_load;
        logic     grav_load;
        logic     quat_load;
        logic     quat_anti;
        logic     var_load;
        logic     var_const;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic calibrated;
        logic in_window;
        logic count_short;
        logic axis_last;
        logic div_done;
        logic sqrt_done;
        logic a_zero;
        logic n2_zero;
        logic g_small;
    } stat_t;

endpackage
`default_nettype wire

@@ rtl/atqe_div.sv @@
// Restoring divider, one quotient bit per cycle, with sticky overflow.
// Depends on atqe_pkg for widths.
`default_nettype none
module atqe_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [atqe_pkg::DVD_W-1:0]   dividend,
    input  wire logic [atqe_pkg::DVS_W-1:0]   divisor,
    input  wire logic [atqe_pkg::ITER_W-1:0]  iters,
    output logic      [atqe_pkg::QUO_W-1:0]   quotient,
    output logic                              ovf,
    output logic                              done
);
    import atqe_pkg::*;

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic              ovf_reg, ovf_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
            cnt_next  = iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            quo_next = {quo_reg[QUO_W-2:0], ge};
            ovf_next = ovf_reg | quo_reg[QUO_W-1];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign quotient = quo_reg;
    assign ovf      = ovf_reg;
    assign done     = done_reg;
endmodule
`default_nettype wire

@@ rtl/atqe_sqrt.sv @@
// Digit-recurrence square root, two radicand bits per cycle, rounded result.
// Depends on atqe_pkg for widths.
`default_nettype none
module atqe_sqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [atqe_pkg::SQ_IN_W-1:0] radicand,
    output logic      [atqe_pkg::ROOT_W-1:0]  root,
    output logic                              done
);
    import atqe_pkg::*;

    localparam int RT_W  = SQ_ITER;
    localparam int REM_W = SQ_ITER + 3;
    localparam int CNT_W = $clog2(SQ_ITER + 1);

    logic [SQ_IN_W-1:0] x_reg, x_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [RT_W-1:0]    rt_reg, rt_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic               ge;

    assign rem_sh = {rem_reg[REM_W-3:0], x_reg[SQ_IN_W-1 -: 2]};
    assign trial  = {1'b0, rt_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        rt_next   = rt_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            rt_next   = '0;
            cnt_next  = CNT_W'(SQ_ITER);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next   = {x_reg[SQ_IN_W-3:0], 2'b00};
            rem_next = ge ? (rem_sh - trial) : rem_sh;
            rt_next  = {rt_reg[RT_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        rem_reg <= rem_next;
        rt_reg  <= rt_next;
    end

    // round up when the remainder exceeds the floor root
    assign root = {1'b0, rt_reg} + ROOT_W'(rem_reg > REM_W'(rt_reg));
    assign done = done_reg;
endmodule
`default_nettype wire

@@ rtl/atqe_datapath.sv @@
// Datapath: config registers, calibration state, shared multiplier,
// accumulator, divider and square root. Depends on atqe_pkg, atqe_div, atqe_sqrt.
`default_nettype none
module atqe_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire atqe_pkg::cmd_t                      cmd,
    output atqe_pkg::stat_t                          stat,
    input  wire logic                                cfg_we,
    input  wire logic        [atqe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [atqe_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic        [atqe_pkg::TIME_W-1:0]  sample_time,
    input  wire logic signed [atqe_pkg::ACCEL_W-1:0] accel_x,
    input  wire logic signed [atqe_pkg::ACCEL_W-1:0] accel_y,
    input  wire logic signed [atqe_pkg::ACCEL_W-1:0] accel_z,
    output logic                                     calibrated,
    output logic                                     calib_retry,
    output logic signed      [atqe_pkg::QUAT_W-1:0]  quat_w,
    output logic signed      [atqe_pkg::QUAT_W-1:0]  quat_x,
    output logic signed      [atqe_pkg::QUAT_W-1:0]  quat_y,
    output logic signed      [atqe_pkg::QUAT_W-1:0]  quat_z,
    output logic             [atqe_pkg::VAR_W-1:0]   tilt_variance,
    output logic             [atqe_pkg::GRAV_W-1:0]  gravity_estimate
);
    import atqe_pkg::*;

    localparam int CX_W = 41;
    localparam int VX_W = 75;

    function automatic logic [ACCEL_W-1:0] abs_a(input logic [ACCEL_W-1:0] v);
        logic [ACCEL_W-1:0] r;
        r = v[ACCEL_W-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    // configuration
    logic [TIME_W-1:0] dur_reg;
    logic [CFG_W-1:0]  noise_reg;
    logic [MIN_W-1:0]  minc_reg;

    // latched sample
    logic [TIME_W-1:0]        t_reg;
    logic signed [ACCEL_W-1:0] a_reg [3];

    // estimator state
    logic                     cal_reg;
    logic                     retry_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [TIME_W-1:0]        end_reg;
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic [GRAV_W-1:0]        grav_reg;
    logic signed [QUAT_W-1:0] q_reg [4];
    logic [VAR_W-1:0]         var_reg;

    // work registers
    logic [AXIS_W-1:0] axis_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [AMAG_W-1:0] amag_reg;
    logic [OPND_W-1:0] nroot_reg;

    // shared units
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic [ITER_W-1:0] div_iters;
    logic [QUO_W-1:0]  div_q;
    logic              div_ovf;
    logic              div_done;
    logic [ROOT_W-1:0] sq_root;
    logic              sq_done;

    logic [TIME_W:0]     end_sum;
    logic [TIME_W-1:0]   end_eff;
    logic [MIN_W-1:0]    minc_eff;
    logic                in_window;
    logic [ACCEL_W-1:0]  a_mag [3];
    logic signed [AMAG_W+1:0] w_s;
    logic [AMAG_W:0]     w_mag;
    logic signed [AMAG_W:0]   d_s;
    logic [AMAG_W:0]     d_mag;
    logic [OPND_W-1:0]   opnd;
    logic [SUM_W-1:0]    sum_mag;
    logic [AMAG_W:0]     c_mag;
    logic                c_neg;
    logic [CX_W-1:0]     x_cal;
    logic [CX_W-1:0]     x_quat;
    logic [VX_W-1:0]     x_var;
    logic signed [QUAT_W-1:0] q_comp;

    assign end_sum  = {1'b0, t_reg} + {1'b0, dur_reg};
    assign end_eff  = (count_reg == '0) ?
                      (end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0]) : end_reg;
    assign in_window = t_reg < end_eff;
    assign minc_eff = (minc_reg == '0) ? MIN_W'(1) : minc_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag[i] = abs_a(a_reg[i]);
        end
    end

    // w = |a| - az, never negative, but keep the sign for safety
    assign w_s   = $signed({2'b00, amag_reg}) - (AMAG_W+2)'(a_reg[2]);
    assign w_mag = w_s[AMAG_W+1] ? AMAG_W'(0) - w_s[AMAG_W:0] : w_s[AMAG_W:0];
    assign d_s   = $signed({1'b0, amag_reg}) - $signed({2'b00, grav_reg});
    assign d_mag = d_s[AMAG_W] ? (~d_s + 1'b1) : d_s;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_AXIS: opnd = OPND_W'(a_mag[axis_reg]);
            MUL_NORM:
            begin
                case (axis_reg)
                    2'd0:    opnd = OPND_W'(w_mag);
                    2'd1:    opnd = OPND_W'(a_mag[0]);
                    default: opnd = OPND_W'(a_mag[1]);
                endcase
            end
            MUL_QUO:  opnd = div_q[OPND_W-1:0];
            MUL_DIFF: opnd = OPND_W'(d_mag);
            MUL_GRAV: opnd = OPND_W'(grav_reg);
            default:  opnd = '0;
        endcase
    end

    // divider operand selection
    assign sum_mag = sum_reg[axis_reg][SUM_W-1] ? (~sum_reg[axis_reg] + 1'b1)
                                                : sum_reg[axis_reg];
    assign x_cal   = CX_W'(sum_mag) + CX_W'(count_reg >> 1);

    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                c_mag = w_mag;
                c_neg = w_s[AMAG_W+1];
            end
            2'd1:
            begin
                c_mag = (AMAG_W+1)'(a_mag[1]);
                c_neg = a_reg[1][ACCEL_W-1];
            end
            default:
            begin
                c_mag = (AMAG_W+1)'(a_mag[0]);
                c_neg = !a_reg[0][ACCEL_W-1] && (a_reg[0] != '0);
            end
        endcase
    end

    assign x_quat = (CX_W'(c_mag) << 14) + CX_W'(nroot_reg >> 1);
    assign x_var  = (VX_W'(acc_reg) << 24) + VX_W'(prod_reg[DVS_W-1:0] >> 1);

    always_comb
    begin
        case (cmd.div_op)
            DIV_CAL:
            begin
                div_dvd   = DVD_W'(x_cal) << (DVD_W - CX_W);
                div_dvs   = DVS_W'(count_reg);
                div_iters = DIV_N_CAL;
            end
            DIV_QUAT:
            begin
                div_dvd   = DVD_W'(x_quat) << (DVD_W - CX_W);
                div_dvs   = DVS_W'(nroot_reg);
                div_iters = DIV_N_QUAT;
            end
            default:
            begin
                div_dvd   = DVD_W'(x_var) << (DVD_W - VX_W);
                div_dvs   = prod_reg[DVS_W-1:0];
                div_iters = DIV_N_VAR;
            end
        endcase
    end

    assign q_comp = c_neg ? -$signed(div_q[QUAT_W-1:0]) : $signed(div_q[QUAT_W-1:0]);

    atqe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .iters    (div_iters),
        .quotient (div_q),
        .ovf      (div_ovf),
        .done     (div_done)
    );

    atqe_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (acc_reg),
        .root     (sq_root),
        .done     (sq_done)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg   <= CALIB_DUR_RST;
            noise_reg <= NOISE_RST;
            minc_reg  <= MIN_CAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CALIB_DUR: dur_reg   <= cfg_data;
                REG_NOISE:     noise_reg <= cfg_data;
                REG_MIN_CAL:   minc_reg  <= cfg_data[MIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // estimator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg   <= 1'b0;
            retry_reg <= 1'b0;
            count_reg <= '0;
            end_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
            grav_reg <= GRAVITY_RST;
            q_reg[0] <= Q14_ONE;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
            var_reg  <= ONE_Q24;
            axis_reg <= '0;
        end
        else
        begin
            if (cmd.in_load)
            begin
                retry_reg <= 1'b0;
            end
            if (cmd.cal_step)
            begin
                end_reg <= end_eff;
                if (in_window)
                begin
                    if (count_reg != '1)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            sum_reg[i] <= sum_reg[i] + SUM_W'(a_reg[i]);
                        end
                        count_reg <= count_reg + 1'b1;
                    end
                end
                else if (count_reg < COUNT_W'(minc_eff))
                begin
                    retry_reg <= 1'b1;
                    count_reg <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_reg[i] <= '0;
                    end
                end
            end
            if (cmd.grav_load)
            begin
                grav_reg <= (sq_root > ROOT_W'(GRAV_SAT)) ? GRAV_SAT : sq_root[GRAV_W-1:0];
                cal_reg  <= 1'b1;
            end
            if (cmd.quat_load)
            begin
                case (axis_reg)
                    2'd0:    q_reg[0] <= q_comp;
                    2'd1:    q_reg[1] <= q_comp;
                    default: q_reg[2] <= q_comp;
                endcase
                q_reg[3] <= '0;
            end
            if (cmd.quat_anti)
            begin
                q_reg[0] <= '0;
                q_reg[1] <= Q14_ONE;
                q_reg[2] <= '0;
                q_reg[3] <= '0;
            end
            if (cmd.var_load)
            begin
                var_reg <= div_ovf ? VAR_SAT : div_q;
            end
            if (cmd.var_const)
            begin
                var_reg <= HALF_PI_SQ_Q24;
            end
            if (cmd.axis_clr)
            begin
                axis_reg <= '0;
            end
            else if (cmd.axis_inc)
            begin
                axis_reg <= axis_reg + 1'b1;
            end
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            t_reg    <= sample_time;
            a_reg[0] <= accel_x;
            a_reg[1] <= accel_y;
            a_reg[2] <= accel_z;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= opnd * opnd;
        end
        case (cmd.acc_op)
            ACC_CLR:   acc_reg <= '0;
            ACC_ADD:   acc_reg <= acc_reg + ACC_W'(prod_reg);
            ACC_NOISE: acc_reg <= acc_reg + ACC_W'({noise_reg, 8'h00});
            default:   ;
        endcase
        if (cmd.amag_load)
        begin
            amag_reg <= sq_root[AMAG_W-1:0];
        end
        if (cmd.nroot_load)
        begin
            nroot_reg <= sq_root[OPND_W-1:0];
        end
        if (cmd.out_load)
        begin
            calibrated       <= cal_reg;
            calib_retry      <= retry_reg;
            quat_w           <= q_reg[0];
            quat_x           <= q_reg[1];
            quat_y           <= q_reg[2];
            quat_z           <= q_reg[3];
            tilt_variance    <= var_reg;
            gravity_estimate <= grav_reg;
        end
    end

    assign stat.calibrated  = cal_reg;
    assign stat.in_window   = in_window;
    assign stat.count_short = count_reg < COUNT_W'(minc_eff);
    assign stat.axis_last   = axis_reg == AXIS_LAST;
    assign stat.div_done    = div_done;
    assign stat.sqrt_done   = sq_done;
    assign stat.a_zero      = (a_reg[0] == '0) && (a_reg[1] == '0) && (a_reg[2] == '0);
    assign stat.n2_zero     = acc_reg == '0;
    assign stat.g_small     = grav_reg[GRAV_W-1:16] == '0;
endmodule
`default_nettype wire

@@ rtl/atqe_ctrl.sv @@
// Controller state machine: sequences the datapath for one sample at a time
// and owns the channel handshakes. Depends on atqe_pkg.
`default_nettype none
module atqe_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire atqe_pkg::stat_t stat,
    output atqe_pkg::cmd_t       cmd
);
    import atqe_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_AXIS;
        cmd.acc_op  = ACC_HOLD;
        cmd.div_op  = DIV_CAL;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.axis_clr = 1'b1;
                cmd.acc_op   = ACC_CLR;
                if (stat.calibrated)
                begin
                    state_next = S_R_MUL;
                end
                else
                begin
                    cmd.cal_step = 1'b1;
                    if (stat.in_window || stat.count_short)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_C_DIV;
                    end
                end
            end
            S_C_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_CAL;
                state_next    = S_C_DIVW;
            end
            S_C_DIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = S_C_MUL;
                end
            end
            S_C_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_QUO;
                state_next  = S_C_ACC;
            end
            S_C_ACC:
            begin
                cmd.acc_op = ACC_ADD;
                if (stat.axis_last)
                begin
                    state_next = S_C_SQ;
                end
                else
                begin
                    cmd.axis_inc = 1'b1;
                    state_next   = S_C_DIV;
                end
            end
            S_C_SQ:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_C_SQW;
            end
            S_C_SQW:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.grav_load = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_R_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AXIS;
                state_next  = S_R_ACC;
            end
            S_R_ACC:
            begin
                cmd.acc_op = ACC_ADD;
                if (stat.axis_last)
                begin
                    state_next = S_R_SQ;
                end
                else
                begin
                    cmd.axis_inc = 1'b1;
                    state_next   = S_R_MUL;
                end
            end
            S_R_SQ:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_R_SQW;
            end
            S_R_SQW:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.amag_load = 1'b1;
                    state_next    = S_R_CHK;
                end
            end
            S_R_CHK:
            begin
                if (stat.a_zero)
                begin
                    state_next = S_V_START;
                end
                else
                begin
                    cmd.axis_clr = 1'b1;
                    cmd.acc_op   = ACC_CLR;
                    state_next   = S_N_MUL;
                end
            end
            S_N_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NORM;
                state_next  = S_N_ACC;
            end
            S_N_ACC:
            begin
                cmd.acc_op = ACC_ADD;
                if (stat.axis_last)
                begin
                    state_next = S_N_CHK;
                end
                else
                begin
                    cmd.axis_inc = 1'b1;
                    state_next   = S_N_MUL;
                end
            end
            S_N_CHK:
            begin
                if (stat.n2_zero)
                begin
                    cmd.quat_anti = 1'b1;
                    state_next    = S_V_START;
                end
                else
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_N_SQW;
                end
            end
            S_N_SQW:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.nroot_load = 1'b1;
                    cmd.axis_clr   = 1'b1;
                    state_next     = S_Q_DIV;
                end
            end
            S_Q_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_QUAT;
                state_next    = S_Q_DIVW;
            end
            S_Q_DIVW:
            begin
                cmd.div_op = DIV_QUAT;
                if (stat.div_done)
                begin
                    cmd.quat_load = 1'b1;
                    if (stat.axis_last)
                    begin
                        state_next = S_V_START;
                    end
                    else
                    begin
                        cmd.axis_inc = 1'b1;
                        state_next   = S_Q_DIV;
                    end
                end
            end
            S_V_START:
            begin
                if (stat.g_small)
                begin
                    cmd.var_const = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.acc_op = ACC_CLR;
                    state_next = S_V_MULD;
                end
            end
            S_V_MULD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DIFF;
                state_next  = S_V_ACCD;
            end
            S_V_ACCD:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_V_NOISE;
            end
            S_V_NOISE:
            begin
                cmd.acc_op  = ACC_NOISE;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GRAV;
                state_next  = S_V_DIV;
            end
            S_V_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_VAR;
                state_next    = S_V_DIVW;
            end
            S_V_DIVW:
            begin
                cmd.div_op = DIV_VAR;
                if (stat.div_done)
                begin
                    cmd.var_load = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & out_stall);
    assign out_valid      = out_valid_reg;
    assign in_stall       = state_reg != S_IDLE;
endmodule
`default_nettype wire

@@ rtl/accel_tilt_quaternion_estimator_core.sv @@
// Top level of the accelerometer tilt estimator with gravity calibration.
// Depends on atqe_pkg, atqe_ctrl and atqe_datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | in_valid / in_stall     | sample_time, accel_x, accel_y, accel_z
//  output   | out_valid / out_stall   | calibrated, calib_retry, quat_w..quat_z,
//           |                         | tilt_variance, gravity_estimate
//  config   | cfg_we (no wait)        | cfg_index, cfg_data
//
// One sample at a time; the shared one-bit-per-cycle divider and
// two-bit-per-cycle square root do the arithmetic. A window sample or a retry
// uses neither; a closing sample that completes calibration takes three
// 41-step divides and a 28-step root; a running sample up to two roots,
// three 41-step divides and a 75-step divide. Reset is asynchronous and
// active low and needs no clearing pass.
// A finished transaction sits in the output register while the next sample
// is taken; completion of the following one waits while out_stall holds it.
`default_nettype none
module accel_tilt_quaternion_estimator_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic        [atqe_pkg::TIME_W-1:0]    sample_time,
    input  wire logic signed [atqe_pkg::ACCEL_W-1:0]   accel_x,
    input  wire logic signed [atqe_pkg::ACCEL_W-1:0]   accel_y,
    input  wire logic signed [atqe_pkg::ACCEL_W-1:0]   accel_z,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       calibrated,
    output logic                                       calib_retry,
    output logic signed      [atqe_pkg::QUAT_W-1:0]    quat_w,
    output logic signed      [atqe_pkg::QUAT_W-1:0]    quat_x,
    output logic signed      [atqe_pkg::QUAT_W-1:0]    quat_y,
    output logic signed      [atqe_pkg::QUAT_W-1:0]    quat_z,
    output logic             [atqe_pkg::VAR_W-1:0]     tilt_variance,
    output logic             [atqe_pkg::GRAV_W-1:0]    gravity_estimate,
    input  wire logic                                  cfg_we,
    input  wire logic        [atqe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [atqe_pkg::CFG_W-1:0]     cfg_data
);
    import atqe_pkg::*;

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: accept one transaction, step the datapath, hand off result
    atqe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: calibration window, shortest-arc quaternion, variance
    atqe_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample_time      (sample_time),
        .accel_x          (accel_x),
        .accel_y          (accel_y),
        .accel_z          (accel_z),
        .calibrated       (calibrated),
        .calib_retry      (calib_retry),
        .quat_w           (quat_w),
        .quat_x           (quat_x),
        .quat_y           (quat_y),
        .quat_z           (quat_z),
        .tilt_variance    (tilt_variance),
        .gravity_estimate (gravity_estimate)
    );
endmodule
`default_nettype wire

@@ rtl/atqe_checker.sv @@
// Port-level checker for the tilt estimator, bound to the top level.
// Depends on atqe_pkg and the assertion macro header.
`default_nettype none
`include "accel_tilt_quaternion_estimator_core_assert.svh"
module atqe_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_valid,
    input wire logic                                  in_stall,
    input wire logic                                  out_valid,
    input wire logic                                  out_stall,
    input wire logic                                  calibrated,
    input wire logic                                  calib_retry,
    input wire logic signed [atqe_pkg::QUAT_W-1:0]    quat_w,
    input wire logic signed [atqe_pkg::QUAT_W-1:0]    quat_x,
    input wire logic signed [atqe_pkg::QUAT_W-1:0]    quat_y,
    input wire logic signed [atqe_pkg::QUAT_W-1:0]    quat_z,
    input wire logic        [atqe_pkg::VAR_W-1:0]     tilt_variance,
    input wire logic        [atqe_pkg::GRAV_W-1:0]    gravity_estimate
);
    import atqe_pkg::*;

    // a taken sample moves the controller out of idle, which raises in_stall
    `ATQE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // a retry never comes with a completed calibration
    `ATQE_ASSERT_IMP(a_retry_uncal, clk, rst_n, out_valid, !(calib_retry && calibrated))

    // before calibration the held attitude is identity with unit variance
    `ATQE_ASSERT_IMP(a_uncal_identity, clk, rst_n, out_valid && !calibrated,
        quat_w == Q14_ONE && quat_x == '0 && quat_y == '0 && quat_z == '0 &&
        tilt_variance == ONE_Q24)

    // a stalled result stays put
    `ATQE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(quat_w) && $stable(tilt_variance) &&
        $stable(gravity_estimate))
endmodule

bind accel_tilt_quaternion_estimator_core atqe_checker u_atqe_checker (.*);
`default_nettype wire

@@ test/tb_accel_tilt_quaternion_estimator_core.sv @@
// Self-checking testbench for the accelerometer tilt estimator core.
// Depends on atqe_pkg and accel_tilt_quaternion_estimator_core.
`default_nettype none

typedef struct {
    logic              calibrated;
    logic              calib_retry;
    logic [15:0]       qw;
    logic [15:0]       qx;
    logic [15:0]       qy;
    logic [15:0]       qz;
    logic [31:0]       variance;
    logic [23:0]       gravity;
} tilt_result_t;

// Scoreboard: holds its own copy of the estimator state and queues the
// result that each accepted sample should produce.
class tilt_scoreboard;
    tilt_result_t       expected_q[$];
    int                 mismatches;
    int                 failures;

    logic [31:0]        duration;
    logic [31:0]        noise;
    logic [15:0]        min_samples;

    bit                 is_cal;
    longint unsigned    count;
    logic [31:0]        end_time;
    longint             accel_sum[3];
    logic [23:0]        gravity;
    logic signed [15:0] quat[4];
    logic [31:0]        variance;

    function new();
        duration    = atqe_pkg::CALIB_DUR_RST;
        noise       = atqe_pkg::NOISE_RST;
        min_samples = atqe_pkg::MIN_CAL_RST;
        is_cal      = 0;
        count       = 0;
        end_time    = 0;
        for (int i = 0; i < 3; i++) accel_sum[i] = 0;
        gravity     = atqe_pkg::GRAVITY_RST;
        quat[0]     = atqe_pkg::Q14_ONE;
        quat[1]     = 0;
        quat[2]     = 0;
        quat[3]     = 0;
        variance    = atqe_pkg::ONE_Q24;
        mismatches  = 0;
        failures    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        if (idx == atqe_pkg::REG_CALIB_DUR) duration = data;
        else if (idx == atqe_pkg::REG_NOISE) noise = data;
        else if (idx == atqe_pkg::REG_MIN_CAL) min_samples = data[15:0];
    endfunction

    function longint unsigned square(longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        return m * m;
    endfunction

    function longint unsigned root_rnd(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return (x > r) ? r + 1 : r;
    endfunction

    function int quat_div(longint c, longint unsigned n);
        longint unsigned mag;
        longint unsigned q;
        mag = (c < 0) ? longint'(-c) : c;
        q = (mag * 16384 + n / 2) / n;
        return (c < 0) ? -int'(q) : int'(q);
    endfunction

    function logic [31:0] var_div(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q = num / den;
        rem = num % den;
        if (q >= 256) return 32'hFFFF_FFFF;
        for (int i = 0; i < 24; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | 1;
            end
        end
        if (rem * 2 >= den) q++;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // Advance the state for one accepted sample and queue its result.
    function void note_sample(logic [31:0] t, logic signed [23:0] ax,
                              logic signed [23:0] ay, logic signed [23:0] az);
        longint          a[3];
        bit              retry;
        longint unsigned e;
        longint unsigned minc;
        longint unsigned s2;
        longint unsigned mag;
        longint unsigned m;
        longint unsigned g;
        longint unsigned amag;
        longint unsigned n2;
        longint unsigned n;
        longint          w;
        longint          d;
        tilt_result_t    r;
        a[0] = ax;
        a[1] = ay;
        a[2] = az;
        retry = 0;
        if (!is_cal)
        begin
            if (count == 0)
            begin
                e = longint'(t) + longint'(duration);
                end_time = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
            end
            if (t < end_time)
            begin
                if (count < 65535)
                begin
                    for (int i = 0; i < 3; i++) accel_sum[i] += a[i];
                    count++;
                end
            end
            else
            begin
                minc = (min_samples != 0) ? min_samples : 1;
                if (count < minc)
                begin
                    retry = 1;
                    count = 0;
                    for (int i = 0; i < 3; i++) accel_sum[i] = 0;
                end
                else
                begin
                    s2 = 0;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag = (accel_sum[i] < 0) ? longint'(-accel_sum[i]) : accel_sum[i];
                        m = (mag + count / 2) / count;
                        s2 += m * m;
                    end
                    g = root_rnd(s2);
                    gravity = (g > 64'hFF_FFFF) ? 24'hFF_FFFF : g[23:0];
                    is_cal = 1;
                end
            end
        end
        else
        begin
            amag = root_rnd(square(a[0]) + square(a[1]) + square(a[2]));
            if (a[0] != 0 || a[1] != 0 || a[2] != 0)
            begin
                w = longint'(amag) - a[2];
                n2 = square(w) + square(a[0]) + square(a[1]);
                if (n2 == 0)
                begin
                    // antiparallel: half turn about x
                    quat[0] = 0;
                    quat[1] = atqe_pkg::Q14_ONE;
                    quat[2] = 0;
                end
                else
                begin
                    n = root_rnd(n2);
                    quat[0] = 16'(quat_div(w, n));
                    quat[1] = 16'(quat_div(a[1], n));
                    quat[2] = 16'(quat_div(-a[0], n));
                end
                quat[3] = 0;
            end
            if (gravity < 24'd65536)
                variance = atqe_pkg::HALF_PI_SQ_Q24;
            else
            begin
                d = longint'(amag) - longint'(gravity);
                variance = var_div(square(d) + (longint'(noise) << 8),
                                   longint'(gravity) * longint'(gravity));
            end
        end
        r.calibrated  = is_cal;
        r.calib_retry = retry;
        r.qw          = quat[0];
        r.qx          = quat[1];
        r.qy          = quat[2];
        r.qz          = quat[3];
        r.variance    = variance;
        r.gravity     = gravity;
        expected_q = {expected_q, r};
    endfunction

    function void check_result(tilt_result_t got);
        tilt_result_t x;
        if (expected_q.size() == 0)
        begin
            failures++;
            $display("unexpected result transaction");
            return;
        end
        x = expected_q.pop_front();
        if (got.calibrated !== x.calibrated || got.calib_retry !== x.calib_retry ||
            got.qw !== x.qw || got.qx !== x.qx || got.qy !== x.qy || got.qz !== x.qz ||
            got.variance !== x.variance || got.gravity !== x.gravity)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch exp cal=%0b rt=%0b q=%h %h %h %h var=%h g=%h",
                         x.calibrated, x.calib_retry, x.qw, x.qx, x.qy, x.qz,
                         x.variance, x.gravity);
                $display("         got cal=%0b rt=%0b q=%h %h %h %h var=%h g=%h",
                         got.calibrated, got.calib_retry, got.qw, got.qx, got.qy, got.qz,
                         got.variance, got.gravity);
            end
        end
    endfunction
endclass

module tb_accel_tilt_quaternion_estimator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import atqe_pkg::*;

    // index 3 is not a register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [31:0]         sample_time;
    logic signed [23:0]  accel_x;
    logic signed [23:0]  accel_y;
    logic signed [23:0]  accel_z;
    logic                out_valid;
    logic                out_stall;
    logic                calibrated;
    logic                calib_retry;
    logic signed [15:0]  quat_w;
    logic signed [15:0]  quat_x;
    logic signed [15:0]  quat_y;
    logic signed [15:0]  quat_z;
    logic [31:0]         tilt_variance;
    logic [23:0]         gravity_estimate;
    logic                cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]         cfg_data;

    // when set, both sides run back to back with no idle cycles
    bit                  burst;
    tilt_scoreboard      sb;

    accel_tilt_quaternion_estimator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample_time(sample_time), .accel_x(accel_x), .accel_y(accel_y),
        .accel_z(accel_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .calibrated(calibrated), .calib_retry(calib_retry),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .tilt_variance(tilt_variance), .gravity_estimate(gravity_estimate),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Sample the result channel; an accepted transaction is valid and not
    // stalled at the edge. Values read here are those from before the edge.
    always @(posedge clk)
    begin
        tilt_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.calibrated  = calibrated;
            got.calib_retry = calib_retry;
            got.qw          = quat_w;
            got.qx          = quat_x;
            got.qy          = quat_y;
            got.qz          = quat_z;
            got.variance    = tilt_variance;
            got.gravity     = gravity_estimate;
            sb.check_result(got);
        end
    end

    // Receiver: hold off a random number of cycles, then take one transaction.
    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = burst ? 0 : $urandom_range(0, 9);
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Drive one sample; idle a random gap first, then hold until accepted.
    task automatic send_sample(logic [31:0] t, logic signed [23:0] x,
                               logic signed [23:0] y, logic signed [23:0] z);
        int n;
        n = burst ? 0 : $urandom_range(0, 9);
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        sample_time <= t;
        accel_x     <= x;
        accel_y     <= y;
        accel_z     <= z;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_sample(t, x, y, z);
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Random running sample: half the time each axis uniform within +/-700000, plus
    // full-range noise, zero vectors, antiparallel and axis extremes.
    task automatic send_running();
        int mode;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1:
            begin
                x = 24'($urandom);
                y = 24'($urandom);
                z = 24'($urandom);
            end
            2:
            begin
                x = 0;
                y = 0;
                z = 0;
            end
            3:
            begin
                x = 0;
                y = 0;
                z = 24'($urandom_range(1, 8388607));
            end
            4:
            begin
                x = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
                y = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
                z = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            end
            default:
            begin
                x = 24'($signed($urandom_range(0, 1400000)) - 700000);
                y = 24'($signed($urandom_range(0, 1400000)) - 700000);
                z = 24'($signed($urandom_range(0, 1400000)) - 700000);
            end
        endcase
        send_sample($urandom, x, y, z);
    endtask

    initial
    begin
        logic [31:0] noise_set[4];
        sb = new();
        burst       = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample_time = '0;
        accel_x     = '0;
        accel_y     = '0;
        accel_z     = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_CALIB_DUR;
        cfg_data    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default window: a few samples, then a close exactly at the end
        // time with too few samples, so calibration retries.
        send_sample(32'd5, 24'sh7FFFFF, 24'sh800000, 24'sh000000);
        send_sample(32'd100, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
        send_sample(32'd200, 24'sh000001, 24'shFFFFFF, 24'sh800000);
        send_sample(32'd300, 24'($urandom), 24'($urandom), 24'($urandom));
        send_sample(32'd1000005, 24'sh0, 24'sh0, 24'sh0);
        drain();

        // Zero-length window with a zero minimum (taken as one) closes on its first sample and retries.
        write_reg(REG_CALIB_DUR, 32'd0);
        write_reg(REG_MIN_CAL, 32'd0);
        send_sample(32'd77, 24'sh123456, 24'sh0, 24'sh0);
        send_sample(32'd0, 24'sh0, 24'sh0, 24'sh0);
        drain();

        // End time saturates at the top of the timestamp range.
        write_reg(REG_CALIB_DUR, 32'hFFFF_FFFF);
        write_reg(REG_MIN_CAL, 32'd5);
        write_reg(REG_NOISE, 32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFF0, 24'sh0, 24'sh0, -24'sd642908);
        send_sample(32'hFFFF_FFFE, 24'sh0, 24'sh0, -24'sd642908);
        send_sample(32'hFFFF_FFFF, 24'sh0, 24'sh0, -24'sd642908);
        drain();

        // Fill a window near one g, then close it with enough samples so
        // calibration completes.
        write_reg(REG_MIN_CAL, 32'd20);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        burst = 1;
        for (int i = 0; i < 24; i++)
            send_sample(32'(i), 24'($signed($urandom_range(0, 2000)) - 1000),
                        24'($signed($urandom_range(0, 2000)) - 1000),
                        24'(-642908 + $signed($urandom_range(0, 2000)) - 1000));
        send_sample(32'hFFFF_FFFF, 24'sh0, 24'sh0, 24'sh0);
        drain();
        burst = 0;

        // Directed running samples at zero noise.
        write_reg(REG_NOISE, 32'd0);
        send_sample(32'd0, 24'sh0, 24'sh0, 24'sh0);
        send_sample(32'd1, 24'sh0, 24'sh0, 24'sh7FFFFF);
        send_sample(32'd2, 24'sh0, 24'sh0, 24'sh000001);
        send_sample(32'd3, 24'sh0, 24'sh0, -24'sd642908);
        send_sample(32'd4, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_sample(32'd5, 24'sh800000, 24'sh800000, 24'sh800000);
        send_sample(32'd6, 24'sh800000, 24'sh0, 24'sh0);
        send_sample(32'd7, 24'sh0, 24'sh7FFFFF, 24'sh0);
        send_sample(32'd8, 24'sh000001, 24'sh0, 24'sh0);
        send_sample(32'hFFFF_FFFF, 24'sh0, 24'sh0, 24'sh800000);
        send_sample(32'd9, 24'sh0, 24'sh0, 24'sh0);
        drain();

        // Random running phases across noise settings; writes to the other
        // registers must not disturb a calibrated block.
        noise_set[0] = 32'hFFFF_FFFF;
        noise_set[1] = 32'd0;
        noise_set[2] = $urandom;
        noise_set[3] = ONE_Q24;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_NOISE, noise_set[p]);
            write_reg(REG_CALIB_DUR, $urandom);
            write_reg(REG_MIN_CAL, $urandom_range(0, 65535));
            burst = (p == 2);
            for (int i = 0; i < 125; i++)
                send_running();
            drain();
        end
        burst = 0;

        repeat (400) @(posedge clk);
        if (sb.mismatches == 0 && sb.failures == 0 && sb.expected_q.size() == 0)
            $display("tb_accel_tilt_quaternion_estimator_core: PASS");
        else
            $display("tb_accel_tilt_quaternion_estimator_core: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #30000000;
        $display("tb_accel_tilt_quaternion_estimator_core: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/atqe_pkg.sv
rtl/atqe_div.sv
rtl/atqe_sqrt.sv
rtl/atqe_datapath.sv
rtl/atqe_ctrl.sv
rtl/accel_tilt_quaternion_estimator_core.sv
rtl/atqe_checker.sv
test/tb_accel_tilt_quaternion_estimator_core.sv
